// ----- design/dep_pkg.sv -----
// Shared types, command codes and constants of the drawing-environment packet builder.
package dep_pkg;

   // GPU command opcodes, already placed in the top byte of a word.
   localparam logic [31:0] CMD_AREA_TL = 32'hE300_0000;
   localparam logic [31:0] CMD_AREA_BR = 32'hE400_0000;
   localparam logic [31:0] CMD_OFFSET  = 32'hE500_0000;
   localparam logic [31:0] CMD_MODE    = 32'hE100_0000;
   localparam logic [31:0] CMD_WINDOW  = 32'hE200_0000;
   localparam logic [31:0] CMD_MASK    = 32'hE600_0000;
   localparam logic [31:0] CMD_RECT    = 32'h6000_0000;
   localparam logic [31:0] CMD_FILL    = 32'h0200_0000;

   // Texture page masks for the two VRAM modes.
   localparam logic [15:0] PAGE_MASK_LARGE = 16'h27FF;
   localparam logic [15:0] PAGE_MASK_SMALL = 16'h09FF;

   // Packet lengths in words.
   localparam logic [3:0] PKT_LEN_SHORT = 4'd6;
   localparam logic [3:0] PKT_LEN_FULL  = 4'd9;

   // Word slots of a packet, in emission order.
   localparam logic [3:0] SLOT_AREA_TL = 4'd0;
   localparam logic [3:0] SLOT_AREA_BR = 4'd1;
   localparam logic [3:0] SLOT_OFFSET  = 4'd2;
   localparam logic [3:0] SLOT_MODE    = 4'd3;
   localparam logic [3:0] SLOT_WINDOW  = 4'd4;
   localparam logic [3:0] SLOT_MASK    = 4'd5;
   localparam logic [3:0] SLOT_FILL    = 4'd6;
   localparam logic [3:0] SLOT_FILL_XY = 4'd7;
   localparam logic [3:0] SLOT_FILL_WH = 4'd8;

   // Configuration register indexes.
   localparam logic [1:0] CSR_LARGE_VRAM  = 2'd0;
   localparam logic [1:0] CSR_VRAM_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_VRAM_HEIGHT = 2'd2;

   localparam logic [12:0] VRAM_WIDTH_RESET  = 13'd1024;
   localparam logic [12:0] VRAM_HEIGHT_RESET = 13'd512;

   typedef struct packed {
      logic        large_vram_mode;
      logic [12:0] vram_width_limit;
      logic [12:0] vram_height_limit;
   } cfg_type;

   typedef struct packed {
      logic [15:0] area_x;
      logic [15:0] area_y;
      logic [15:0] area_width;
      logic [15:0] area_height;
      logic [15:0] draw_offset_x;
      logic [15:0] draw_offset_y;
      logic [15:0] texture_page;
      logic [2:0]  flags;
      logic [15:0] window_offset;
      logic [31:0] window_size;
      logic [23:0] clear_color;
   } item_type;

endpackage

// ----- design/dep_csr.sv -----
// Configuration registers of the drawing-environment packet builder.
module dep_csr (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_enable,
   input  logic [1:0]      csr_index,
   input  logic [12:0]     csr_write_data,
   output dep_pkg::cfg_type cfg
);
   import dep_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_LARGE_VRAM:  cfg_in.large_vram_mode   = csr_write_data[0];
            CSR_VRAM_WIDTH:  cfg_in.vram_width_limit  = csr_write_data;
            CSR_VRAM_HEIGHT: cfg_in.vram_height_limit = csr_write_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.large_vram_mode   <= 1'b0;
         cfg_ff.vram_width_limit  <= VRAM_WIDTH_RESET;
         cfg_ff.vram_height_limit <= VRAM_HEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/dep_word_gen.sv -----
// Combinational builder of one packet word, selected by its slot number.
module dep_word_gen (
   input  dep_pkg::cfg_type  cfg,
   input  dep_pkg::item_type item,
   input  logic [3:0]        slot,
   output logic [31:0]       word,
   output logic [3:0]        length
);
   import dep_pkg::*;

   // Clamp a signed coordinate to 0 .. limit-1; a zero limit behaves as one.
   function automatic logic [12:0] clamp_coord(input logic [15:0] v, input logic [12:0] limit);
      logic [12:0] hi;
      hi = (limit == 13'd0) ? 13'd0 : limit - 13'd1;
      if (v[15]) begin
         return 13'd0;
      end else if (v[14:0] > {2'b00, hi}) begin
         return hi;
      end else begin
         return v[12:0];
      end
   endfunction

   logic [15:0] br_x;
   logic [15:0] br_y;
   logic [15:0] corner_x;
   logic [15:0] corner_y;
   logic [12:0] cx;
   logic [12:0] cy;
   logic [31:0] area_cmd;
   logic [31:0] area_word;
   logic [15:0] neg_w;
   logic [15:0] neg_h;
   logic [15:0] page_bits;
   logic        fast_fill;
   logic [15:0] rel_x;
   logic [15:0] rel_y;

   assign br_x = item.area_x + item.area_width - 16'd1;
   assign br_y = item.area_y + item.area_height - 16'd1;

   // One clamp pair serves both area corners.
   assign corner_x = (slot == SLOT_AREA_BR) ? br_x : item.area_x;
   assign corner_y = (slot == SLOT_AREA_BR) ? br_y : item.area_y;
   assign area_cmd = (slot == SLOT_AREA_BR) ? CMD_AREA_BR : CMD_AREA_TL;
   assign cx = clamp_coord(corner_x, cfg.vram_width_limit);
   assign cy = clamp_coord(corner_y, cfg.vram_height_limit);

   always_comb begin
      if (cfg.large_vram_mode) begin
         area_word = area_cmd | {8'h00, cy[11:0], cx[11:0]};
      end else begin
         area_word = area_cmd | {12'h000, cy[9:0], cx[9:0]};
      end
   end

   always_comb begin
      if (cfg.large_vram_mode) begin
         page_bits = (item.texture_page & PAGE_MASK_LARGE)
                   | {3'b000, item.flags[1], item.flags[0], 11'h000};
      end else begin
         page_bits = (item.texture_page & PAGE_MASK_SMALL)
                   | {5'b00000, item.flags[1], item.flags[0], 9'h000};
      end
   end

   assign neg_w = 16'd0 - item.window_size[15:0];
   assign neg_h = 16'd0 - item.window_size[31:16];

   assign fast_fill = (item.area_x[5:0] == 6'd0) && (item.area_width[5:0] == 6'd0);
   assign rel_x = item.area_x - item.draw_offset_x;
   assign rel_y = item.area_y - item.draw_offset_y;

   assign length = item.flags[2] ? PKT_LEN_FULL : PKT_LEN_SHORT;

   always_comb begin
      case (slot)
         SLOT_AREA_TL, SLOT_AREA_BR: word = area_word;
         SLOT_OFFSET: begin
            if (cfg.large_vram_mode) begin
               word = CMD_OFFSET
                    | {8'h00, item.draw_offset_y[11:0], item.draw_offset_x[11:0]};
            end else begin
               word = CMD_OFFSET
                    | {10'h000, item.draw_offset_y[10:0], item.draw_offset_x[10:0]};
            end
         end
         SLOT_MODE:   word = CMD_MODE | {16'h0000, page_bits};
         SLOT_WINDOW: word = CMD_WINDOW | {12'h000, item.window_offset[15:11],
                                           item.window_offset[7:3], neg_h[7:3], neg_w[7:3]};
         SLOT_MASK:   word = CMD_MASK;
         SLOT_FILL:   word = (fast_fill ? CMD_FILL : CMD_RECT) | {8'h00, item.clear_color};
         SLOT_FILL_XY: begin
            if (fast_fill) begin
               word = {item.area_y, item.area_x};
            end else begin
               word = {rel_y, rel_x};
            end
         end
         SLOT_FILL_WH: word = {item.area_height, item.area_width};
         default:      word = 32'h0000_0000;
      endcase
   end

endmodule

// ----- design/draw_environment_packet_builder_core.sv -----
// Top level of the drawing-environment packet builder: input hold register, word sequencer, result register.
//
// Each accepted word on the request channel describes one drawing environment and turns into a
// packet of six GPU command words (draw area top-left and bottom-right, drawing offset, draw mode,
// texture window, mask setting), or nine when the clear flag is set, in which case a fast fill or
// a monochrome rectangle of three words follows. The result channel carries one command word per
// cycle while the result side keeps taking words; a stall there holds the flow, and every word passes
// through the single result register. A description waits in a hold register while a word
// counter steps through its slots; each word is built by short combinational logic from the hold
// register and the configuration, and lands in the result register. The next description is taken
// in the same cycle that the final word of the current packet moves into the result register, so
// packets stream without gaps as long as the result side keeps taking words. Configuration writes
// take effect on the next clock and must only happen while no packet is in flight.
module draw_environment_packet_builder_core (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_write_data,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic signed [15:0] req_area_x,
   input  logic signed [15:0] req_area_y,
   input  logic signed [15:0] req_area_width,
   input  logic signed [15:0] req_area_height,
   input  logic signed [15:0] req_draw_offset_x,
   input  logic signed [15:0] req_draw_offset_y,
   input  logic [15:0] req_texture_page,
   input  logic [2:0]  req_flags,
   input  logic [15:0] req_window_offset,
   input  logic [31:0] req_window_size,
   input  logic [23:0] req_clear_color,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_packet_word,
   output logic [3:0]  rsp_packet_length,
   output logic        rsp_last_word
);
   import dep_pkg::*;

   cfg_type     cfg;
   item_type    req_item;

   // Hold register: the description whose words are being emitted.
   item_type    item_ff;
   logic        hold_valid_ff;
   logic        hold_valid_in;
   logic [3:0]  slot_ff;
   logic [3:0]  slot_in;

   // Result register.
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [31:0] word_ff;
   logic [3:0]  length_ff;
   logic        last_ff;

   logic [31:0] word;
   logic [3:0]  length;
   logic        advance;
   logic        final_slot;
   logic        req_accept;

   dep_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   dep_word_gen u_word_gen (
      .cfg    (cfg),
      .item   (item_ff),
      .slot   (slot_ff),
      .word   (word),
      .length (length)
   );

   assign req_item.area_x        = req_area_x;
   assign req_item.area_y        = req_area_y;
   assign req_item.area_width    = req_area_width;
   assign req_item.area_height   = req_area_height;
   assign req_item.draw_offset_x = req_draw_offset_x;
   assign req_item.draw_offset_y = req_draw_offset_y;
   assign req_item.texture_page  = req_texture_page;
   assign req_item.flags         = req_flags;
   assign req_item.window_offset = req_window_offset;
   assign req_item.window_size   = req_window_size;
   assign req_item.clear_color   = req_clear_color;

   // A held description hands a word to the result register when that register is empty or being emptied.
   assign advance    = hold_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign final_slot = (slot_ff == length - 4'd1);

   // The hold register frees up in the cycle its final word is handed on.
   assign req_ready  = !hold_valid_ff || (advance && final_slot);
   assign req_accept = req_valid && req_ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      slot_in       = slot_ff;
      if (advance) begin
         slot_in = final_slot ? 4'd0 : slot_ff + 4'd1;
         if (final_slot) begin
            hold_valid_in = 1'b0;
         end
      end
      if (req_accept) begin
         hold_valid_in = 1'b1;
         slot_in       = 4'd0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         slot_ff       <= 4'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         slot_ff       <= slot_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_item;
      end
      if (advance) begin
         word_ff   <= word;
         length_ff <= length;
         last_ff   <= final_slot;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_packet_word   = word_ff;
   assign rsp_packet_length = length_ff;
   assign rsp_last_word     = last_ff;

`ifndef NO_ASSERTIONS
   // The word counter never runs past the length of the packet being built.
   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> (slot_ff < length))
      else $error("word counter beyond packet length");

   // Every delivered word carries one of the two legal packet lengths.
   a_length_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_packet_length == PKT_LEN_SHORT || rsp_packet_length == PKT_LEN_FULL))
      else $error("illegal packet length on result channel");

   // When the final word moves on and no description is accepted, the hold register is left empty.
   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      (advance && final_slot && !req_accept) |=> !hold_valid_ff)
      else $error("sequencer kept running after final word");

   // Reset empties both the hold and the result register.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !hold_valid_ff))
      else $error("reset did not clear the pipeline");
`endif

endmodule
